FILE: hw/rtl/pgvu_pkg.sv
// Shared types and constants for the point gravity velocity update core.
// No dependencies; imported by point_gravity_velocity_update_core.
package pgvu_pkg;

    // Fraction bits of every Q-format value on the ports.
    localparam int FRAC_BITS = 16;

    // Pipeline section lengths.
    localparam int SQ_STEPS  = 31;                   // square root, one root bit per stage
    localparam int QD_STEPS  = 34;                   // mu*dt / (S >> 30), one bit per stage
    localparam int WD_STEPS  = 31;                   // u * 2^30 / r, one bit per stage
    localparam int MID_LEN   = SQ_STEPS + WD_STEPS;
    localparam int Q_DLY     = MID_LEN - QD_STEPS;

    // Largest left shift applied to the scaled product.
    localparam int SHL_MAX   = 2 * 29 + FRAC_BITS - 60;
    localparam int SHW       = 64 + SHL_MAX;

    localparam logic [33:0] MAG_CAP = 34'h2_0000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_STRENGTH  = 3'd3,
        REG_TIME_STEP = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               singular;
        logic               saturated;
    } t_result;

    // Per-item data that rides alongside the arithmetic stages.
    typedef struct packed {
        logic               sing;
        logic [2:0]         neg;
        logic [2:0]         zero;
        logic [2:0][31:0]   vel;
        logic [2:0][29:0]   u;
        logic signed [5:0]  e;
    } t_side;

    // Bit length of a value (0 for zero).
    function automatic logic [6:0] f_bitlen(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/point_gravity_velocity_update_core.sv
// Point gravity velocity update core: top level, APB register file and full pipeline.
// Depends on pgvu_pkg (types, constants, bit-length function).
//
// Takes one particle (position, velocity; signed Q16.16) per clock and returns the
// velocity plus dt*mu*D/|D|^3, D = position - attractor, saturated to 32 bits. busy is
// never raised, so an item is taken on every cycle that start is high. The result for an
// item appears on o_result with o_done high for one cycle, in input order; the receiver
// cannot stall it. The pipeline is dominated by the bit-serial square root (31 stages)
// followed by the bit-serial normalizing divide (31 stages); the mu*dt/S divide runs
// beside the root. The user must write registers over APB only while no item is in
// flight (not enforced). A write updates mu*dt in r_p1, then its normalization in r_pn.
module point_gravity_velocity_update_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pgvu_pkg::t_item   i_item,
    output logic              o_done,
    output pgvu_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pgvu_pkg::*;

    localparam logic signed [8:0] SH_BIAS = 9'(FRAC_BITS - 60);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [2:0][31:0] r_center;
    logic [31:0]      r_strength;
    logic [30:0]      r_time_step;
    t_reg_idx         reg_idx;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center    <= '0;
            r_strength  <= '0;
            r_time_step <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_CENTER_X:  r_center[0]  <= pwdata;
                REG_CENTER_Y:  r_center[1]  <= pwdata;
                REG_CENTER_Z:  r_center[2]  <= pwdata;
                REG_STRENGTH:  r_strength   <= pwdata;
                REG_TIME_STEP: r_time_step  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X:  prdata = r_center[0];
            REG_CENTER_Y:  prdata = r_center[1];
            REG_CENTER_Z:  prdata = r_center[2];
            REG_STRENGTH:  prdata = r_strength;
            REG_TIME_STEP: prdata = {1'b0, r_time_step};
            default:       prdata = '0;
        endcase
    end

    // mu*dt, then normalized so Pn lies in [2^61, 2^62); p is the shift used.
    logic [31:0] str_mag;
    logic [62:0] p1_full;
    logic [6:0]  p1_len;
    logic [61:0] r_p1, r_pn;
    logic [5:0]  r_pexp;
    logic [5:0]  n_pexp;

    always_comb begin
        str_mag = r_strength[31] ? (32'd0 - r_strength) : r_strength;
        p1_full = r_time_step * str_mag;
        p1_len  = f_bitlen({2'b0, r_p1});
        n_pexp  = 6'(7'd62 - p1_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1   <= '0;
            r_pn   <= '0;
            r_pexp <= '0;
        end else begin
            r_p1   <= p1_full[61:0];
            r_pn   <= r_p1 << n_pexp;
            r_pexp <= n_pexp;
        end
    end

    // ------------------------------------------------------------------
    // Front: difference, magnitude, exponent, normalize, square, sum
    // ------------------------------------------------------------------
    logic [5:0]        r_vld_f;
    logic [2:0][32:0]  r_f1_d;
    logic [2:0][31:0]  r_f1_vel;
    logic [2:0][32:0]  r_f2_mag, r_f3_mag;
    t_side             r_f2_sd, r_f3_sd, r_f4_sd, r_f5_sd, r_f6_sd;
    logic [2:0][59:0]  r_f5_sq;
    logic [61:0]       r_f6_s;

    logic [2:0][31:0]  pos_in, vel_in;
    logic [2:0][32:0]  n_f1_d, n_f2_mag;
    t_side             n_f2_sd, n_f3_sd, n_f4_sd;
    logic [2:0][59:0]  n_f5_sq;
    logic [61:0]       n_f6_s;
    logic [6:0]        amax_len;
    logic signed [7:0] e_w;
    logic [5:0]        nege;
    logic [62:0]       shl_tmp;
    logic [32:0]       shr_tmp;

    always_comb begin
        pos_in = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
        vel_in = {i_item.vel_z, i_item.vel_y, i_item.vel_x};
        for (int i = 0; i < 3; i++) begin
            n_f1_d[i] = {pos_in[i][31], pos_in[i]} - {r_center[i][31], r_center[i]};
        end

        n_f2_sd      = r_f2_sd;
        n_f2_sd.sing = 1'b0;
        n_f2_sd.u    = '0;
        n_f2_sd.e    = '0;
        n_f2_sd.vel  = r_f1_vel;
        for (int i = 0; i < 3; i++) begin
            n_f2_mag[i]     = r_f1_d[i][32] ? (33'd0 - r_f1_d[i]) : r_f1_d[i];
            n_f2_sd.neg[i]  = r_f1_d[i][32];
            n_f2_sd.zero[i] = (r_f1_d[i] == '0);
        end

        // bit length of the largest magnitude equals that of the OR of all three
        amax_len     = f_bitlen({31'b0, r_f2_mag[0] | r_f2_mag[1] | r_f2_mag[2]});
        e_w          = 8'sd30 - $signed({1'b0, amax_len});
        n_f3_sd      = r_f2_sd;
        n_f3_sd.e    = e_w[5:0];
        n_f3_sd.sing = (amax_len == '0);

        n_f4_sd = r_f3_sd;
        nege    = 6'd0 - r_f3_sd.e;
        shl_tmp = '0;
        shr_tmp = '0;
        for (int i = 0; i < 3; i++) begin
            if (!r_f3_sd.e[5]) begin
                shl_tmp       = {30'b0, r_f3_mag[i]} << r_f3_sd.e[4:0];
                n_f4_sd.u[i]  = shl_tmp[29:0];
            end else begin
                shr_tmp       = r_f3_mag[i] >> nege[2:0];
                n_f4_sd.u[i]  = shr_tmp[29:0];
            end
        end

        for (int i = 0; i < 3; i++) begin
            n_f5_sq[i] = r_f4_sd.u[i] * r_f4_sd.u[i];
        end

        n_f6_s = {2'b0, r_f5_sq[0]} + {2'b0, r_f5_sq[1]} + {2'b0, r_f5_sq[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= '0;
        end else begin
            r_vld_f <= {r_vld_f[4:0], start && !busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_d   <= n_f1_d;
        r_f1_vel <= vel_in;
        r_f2_mag <= n_f2_mag;
        r_f2_sd  <= n_f2_sd;
        r_f3_mag <= r_f2_mag;
        r_f3_sd  <= n_f3_sd;
        r_f4_sd  <= n_f4_sd;
        r_f5_sd  <= r_f4_sd;
        r_f5_sq  <= n_f5_sq;
        r_f6_sd  <= r_f5_sd;
        r_f6_s   <= n_f6_s;
    end

    // ------------------------------------------------------------------
    // Middle: square root, then u*2^30/r; mu*dt/(S>>30) alongside
    // ------------------------------------------------------------------
    logic [MID_LEN-1:0] r_vld_m;
    t_side              r_sd [MID_LEN];

    logic [32:0] r_sq_rem  [SQ_STEPS];
    logic [30:0] r_sq_root [SQ_STEPS];
    logic [61:0] r_sq_s    [SQ_STEPS];
    logic [32:0] n_sq_rem  [SQ_STEPS];
    logic [30:0] n_sq_root [SQ_STEPS];
    logic [61:0] n_sq_s    [SQ_STEPS];

    logic [31:0] r_qd_rem  [QD_STEPS];
    logic [33:0] r_qd_q    [QD_STEPS];
    logic [31:0] r_qd_dv   [QD_STEPS];
    logic [31:0] n_qd_rem  [QD_STEPS];
    logic [33:0] n_qd_q    [QD_STEPS];
    logic [31:0] n_qd_dv   [QD_STEPS];
    logic [33:0] r_qdl     [Q_DLY];

    logic [2:0][30:0] r_wd_rem [WD_STEPS];
    logic [2:0][30:0] r_wd_q   [WD_STEPS];
    logic [30:0]      r_wd_dv  [WD_STEPS];
    logic [2:0][30:0] n_wd_rem [WD_STEPS];
    logic [2:0][30:0] n_wd_q   [WD_STEPS];
    logic [30:0]      n_wd_dv  [WD_STEPS];

    logic [32:0] sq_rem_in;
    logic [30:0] sq_root_in;
    logic [61:0] sq_s_in;
    logic [34:0] sq_pre, sq_trial;

    always_comb begin
        for (int j = 0; j < SQ_STEPS; j++) begin
            sq_rem_in  = (j == 0) ? 33'd0 : r_sq_rem[j - 1];
            sq_root_in = (j == 0) ? 31'd0 : r_sq_root[j - 1];
            sq_s_in    = (j == 0) ? r_f6_s : r_sq_s[j - 1];
            sq_pre     = {sq_rem_in, sq_s_in[2 * (SQ_STEPS - 1 - j) + 1 -: 2]};
            sq_trial   = {2'b0, sq_root_in, 2'b01};
            if (sq_pre >= sq_trial) begin
                sq_pre       = sq_pre - sq_trial;
                n_sq_root[j] = {sq_root_in[29:0], 1'b1};
            end else begin
                n_sq_root[j] = {sq_root_in[29:0], 1'b0};
            end
            n_sq_rem[j] = sq_pre[32:0];
            n_sq_s[j]   = sq_s_in;
        end
    end

    logic [31:0] qd_rem_in, qd_dv_in;
    logic [33:0] qd_q_in;
    logic [32:0] qd_t;

    always_comb begin
        for (int j = 0; j < QD_STEPS; j++) begin
            qd_rem_in = (j == 0) ? {4'b0, r_pn[61:34]} : r_qd_rem[j - 1];
            qd_q_in   = (j == 0) ? 34'd0 : r_qd_q[j - 1];
            qd_dv_in  = (j == 0) ? r_f6_s[61:30] : r_qd_dv[j - 1];
            qd_t      = {qd_rem_in, r_pn[QD_STEPS - 1 - j]};
            if (qd_t >= {1'b0, qd_dv_in}) begin
                qd_t      = qd_t - {1'b0, qd_dv_in};
                n_qd_q[j] = {qd_q_in[32:0], 1'b1};
            end else begin
                n_qd_q[j] = {qd_q_in[32:0], 1'b0};
            end
            n_qd_rem[j] = qd_t[31:0];
            n_qd_dv[j]  = qd_dv_in;
        end
    end

    logic [30:0] wd_rem_in, wd_q_in, wd_dv_in;
    logic        wd_nb;
    logic [31:0] wd_t;

    always_comb begin
        for (int j = 0; j < WD_STEPS; j++) begin
            wd_dv_in   = (j == 0) ? r_sq_root[SQ_STEPS - 1] : r_wd_dv[j - 1];
            n_wd_dv[j] = wd_dv_in;
            for (int i = 0; i < 3; i++) begin
                // numerator u*2^30: only its lowest live bit is u[0]
                if (j == 0) begin
                    wd_rem_in = {2'b0, r_sd[SQ_STEPS - 1].u[i][29:1]};
                    wd_q_in   = '0;
                    wd_nb     = r_sd[SQ_STEPS - 1].u[i][0];
                end else begin
                    wd_rem_in = r_wd_rem[j - 1][i];
                    wd_q_in   = r_wd_q[j - 1][i];
                    wd_nb     = 1'b0;
                end
                wd_t = {wd_rem_in, wd_nb};
                if (wd_t >= {1'b0, wd_dv_in}) begin
                    wd_t         = wd_t - {1'b0, wd_dv_in};
                    n_wd_q[j][i] = {wd_q_in[29:0], 1'b1};
                end else begin
                    n_wd_q[j][i] = {wd_q_in[29:0], 1'b0};
                end
                n_wd_rem[j][i] = wd_t[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_m <= '0;
        end else begin
            r_vld_m <= {r_vld_m[MID_LEN-2:0], r_vld_f[5]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_f6_sd;
        for (int j = 1; j < MID_LEN; j++) begin
            r_sd[j] <= r_sd[j - 1];
        end
        for (int j = 0; j < SQ_STEPS; j++) begin
            r_sq_rem[j]  <= n_sq_rem[j];
            r_sq_root[j] <= n_sq_root[j];
            r_sq_s[j]    <= n_sq_s[j];
        end
        for (int j = 0; j < QD_STEPS; j++) begin
            r_qd_rem[j] <= n_qd_rem[j];
            r_qd_q[j]   <= n_qd_q[j];
            r_qd_dv[j]  <= n_qd_dv[j];
        end
        r_qdl[0] <= r_qd_q[QD_STEPS - 1];
        for (int j = 1; j < Q_DLY; j++) begin
            r_qdl[j] <= r_qdl[j - 1];
        end
        for (int j = 0; j < WD_STEPS; j++) begin
            r_wd_rem[j] <= n_wd_rem[j];
            r_wd_q[j]   <= n_wd_q[j];
            r_wd_dv[j]  <= n_wd_dv[j];
        end
    end

    // ------------------------------------------------------------------
    // Tail: Q*W in two halves, sum, scale and cap, add and clamp
    // ------------------------------------------------------------------
    logic [2:0]        r_vld_t;
    t_side             r_t1_sd, r_t2_sd, r_t3_sd;
    logic [2:0][47:0]  r_t1_lo, r_t1_hi;
    logic signed [8:0] r_t1_sh, r_t2_sh;
    logic [2:0][63:0]  r_t2_x;
    logic [2:0][33:0]  r_t3_m;
    logic              r_done;
    t_result           r_result;

    logic [33:0]       q_fin;
    logic [2:0][47:0]  n_t1_lo, n_t1_hi;
    logic signed [8:0] e_ext, p_ext, n_t1_sh;
    logic [2:0][63:0]  n_t2_x;
    logic [64:0]       x_sum;
    logic [2:0][33:0]  n_t3_m;
    logic [SHW-1:0]    y_shl;
    logic [8:0]        nsh;
    logic [63:0]       x_shr;
    logic [2:0][31:0]  nv_sel;
    logic signed [35:0] nv;
    logic              sat;
    t_result           n_result;

    always_comb begin
        q_fin = r_qdl[Q_DLY - 1];
        for (int i = 0; i < 3; i++) begin
            n_t1_lo[i] = q_fin[16:0] * r_wd_q[WD_STEPS - 1][i];
            n_t1_hi[i] = q_fin[33:17] * r_wd_q[WD_STEPS - 1][i];
        end
        e_ext   = {{3{r_sd[MID_LEN - 1].e[5]}}, r_sd[MID_LEN - 1].e};
        p_ext   = {3'b0, r_pexp};
        n_t1_sh = e_ext + e_ext + SH_BIAS - p_ext;

        for (int i = 0; i < 3; i++) begin
            x_sum     = {r_t1_hi[i], 17'b0} + {17'b0, r_t1_lo[i]};
            n_t2_x[i] = x_sum[63:0];
        end

        y_shl = '0;
        x_shr = '0;
        nsh   = 9'd0 - r_t2_sh;
        for (int i = 0; i < 3; i++) begin
            if (!r_t2_sh[8]) begin
                y_shl = {{SHL_MAX{1'b0}}, r_t2_x[i]} << r_t2_sh[7:0];
                n_t3_m[i] = (y_shl > SHW'(MAG_CAP)) ? MAG_CAP : y_shl[33:0];
            end else if (nsh >= 9'd64) begin
                n_t3_m[i] = '0;
            end else begin
                x_shr = r_t2_x[i] >> nsh[5:0];
                n_t3_m[i] = (x_shr > 64'(MAG_CAP)) ? MAG_CAP : x_shr[33:0];
            end
            if (r_t2_sd.zero[i]) begin
                n_t3_m[i] = '0;
            end
        end

        sat = 1'b0;
        nv  = '0;
        for (int i = 0; i < 3; i++) begin
            // increment sign follows D, flipped by a negative strength
            if (r_t3_sd.neg[i] != r_strength[31]) begin
                nv = {{4{r_t3_sd.vel[i][31]}}, r_t3_sd.vel[i]} - {2'b0, r_t3_m[i]};
            end else begin
                nv = {{4{r_t3_sd.vel[i][31]}}, r_t3_sd.vel[i]} + {2'b0, r_t3_m[i]};
            end
            if (nv > 36'sd2147483647) begin
                nv_sel[i] = 32'h7FFF_FFFF;
                sat       = 1'b1;
            end else if (nv < -36'sd2147483648) begin
                nv_sel[i] = 32'h8000_0000;
                sat       = 1'b1;
            end else begin
                nv_sel[i] = nv[31:0];
            end
        end

        if (r_t3_sd.sing) begin
            n_result.new_vel_x = r_t3_sd.vel[0];
            n_result.new_vel_y = r_t3_sd.vel[1];
            n_result.new_vel_z = r_t3_sd.vel[2];
            n_result.singular  = 1'b1;
            n_result.saturated = 1'b0;
        end else begin
            n_result.new_vel_x = nv_sel[0];
            n_result.new_vel_y = nv_sel[1];
            n_result.new_vel_z = nv_sel[2];
            n_result.singular  = 1'b0;
            n_result.saturated = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_t <= '0;
            r_done  <= 1'b0;
        end else begin
            r_vld_t <= {r_vld_t[1:0], r_vld_m[MID_LEN - 1]};
            r_done  <= r_vld_t[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1_sd  <= r_sd[MID_LEN - 1];
        r_t1_lo  <= n_t1_lo;
        r_t1_hi  <= n_t1_hi;
        r_t1_sh  <= n_t1_sh;
        r_t2_sd  <= r_t1_sd;
        r_t2_x   <= n_t2_x;
        r_t2_sh  <= r_t1_sh;
        r_t3_sd  <= r_t2_sd;
        r_t3_m   <= n_t3_m;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
